// File: rtl/core/aes_cfb_pkg.sv
// Shared types, constants and AES helper functions for the AES-128 CFB unit.
`default_nettype none
package aes_cfb_pkg;

  localparam int BlockBits = 128;
  localparam int CountBits = 5;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 64;
  // AES-128 runs ten rounds after the initial key addition.
  localparam int AesRounds = 10;

  localparam logic [CfgIdxBits-1:0] RegKeyHigh = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegKeyLow  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegIvHigh  = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegIvLow   = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegDecrypt = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } ctrl_state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;   // capture the request and start round zero
    logic round;  // perform one AES round
    logic last;   // the round performed is the final one
    logic finish; // build the result and update the feedback
  } dp_cmd_t;

  typedef struct packed {
    logic [CountBits-1:0] count;
    logic                 first;
  } req_info_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit block, byte 0 most significant.
  function automatic logic [7:0] get_byte(input logic [BlockBits-1:0] v, input int i);
    return v[BlockBits-1-8*i -: 8];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/aes_cfb_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface aes_cfb_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic [4:0]  byte_count;
  logic        first_block;
  modport source (output valid, data_high, data_low, byte_count, first_block, input ready);
  modport sink (input valid, data_high, data_low, byte_count, first_block, output ready);
endinterface

interface aes_cfb_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic [4:0]  out_count;
  modport source (output valid, out_high, out_low, out_count, input ready);
  modport sink (input valid, out_high, out_low, out_count, output ready);
endinterface
`default_nettype wire

// File: rtl/core/aes_cfb_ctrl.sv
// Controller state machine sequencing the AES rounds of one request.
`default_nettype none
module aes_cfb_ctrl (
  input  wire  logic               clk,
  input  wire  logic               rst,
  input  wire  logic               in_valid,
  output       logic               in_ready,
  output       logic               out_valid,
  input  wire  logic               out_ready,
  output       aes_cfb_pkg::dp_cmd_t cmd
);
  import aes_cfb_pkg::*;

  localparam int CntBits = $clog2(AesRounds + 1);

  ctrl_state_t state, state_next;
  logic [CntBits-1:0] rnd, rnd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
    end
  end

  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          rnd_next   = CntBits'(1);
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + CntBits'(1);
        if (rnd == CntBits'(AesRounds)) begin
          cmd.last   = 1'b1;
          cmd.finish = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        // The result register frees here, so a new request may load at once.
        if (out_ready) begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load   = 1'b1;
            rnd_next   = CntBits'(1);
            state_next = ST_RUN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/core/aes_cfb_dp.sv
// Datapath: AES round unit, on-the-fly key schedule, feedback and result registers.
`default_nettype none
module aes_cfb_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire aes_cfb_pkg::dp_cmd_t  cmd,
  input  wire logic [127:0]          key,
  input  wire logic [127:0]          iv,
  input  wire logic                  decrypt,
  input  wire logic [127:0]          din,
  input  wire aes_cfb_pkg::req_info_t info,
  output      logic [127:0]          res,
  output      logic [4:0]            res_count
);
  import aes_cfb_pkg::*;

  logic [127:0] fb;
  logic [127:0] st;
  logic [127:0] rk;
  logic [7:0]   rcon;
  logic [127:0] data;
  logic [4:0]   cnt;

  logic [127:0] fb_eff, rk_next, rnd_out, sb, sr, mc, out_c, fb_c;
  logic [31:0]  w3t;
  logic [4:0]   cnt_sat;

  assign fb_eff  = info.first ? iv : fb;
  assign cnt_sat = (info.count > 5'd16) ? 5'd16 : info.count;

  // Next round key from the current one.
  always_comb begin
    w3t = {sbox(rk[23:16]) ^ rcon, sbox(rk[15:8]), sbox(rk[7:0]), sbox(rk[31:24])};
    rk_next[127:96] = rk[127:96] ^ w3t;
    rk_next[95:64]  = rk[95:64] ^ rk_next[127:96];
    rk_next[63:32]  = rk[63:32] ^ rk_next[95:64];
    rk_next[31:0]   = rk[31:0] ^ rk_next[63:32];
  end

  // One round: SubBytes, ShiftRows, MixColumns (skipped on last), AddRoundKey.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[127-8*i -: 8] = sbox(get_byte(st, i));
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127-8*(4*c+r) -: 8] = get_byte(sb, ((c + r) % 4) * 4 + r);
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, x;
      a0 = get_byte(sr, 4*c);
      a1 = get_byte(sr, 4*c+1);
      a2 = get_byte(sr, 4*c+2);
      a3 = get_byte(sr, 4*c+3);
      x  = a0 ^ a1 ^ a2 ^ a3;
      mc[127-8*(4*c)   -: 8] = a0 ^ x ^ xtime(a0 ^ a1);
      mc[127-8*(4*c+1) -: 8] = a1 ^ x ^ xtime(a1 ^ a2);
      mc[127-8*(4*c+2) -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
      mc[127-8*(4*c+3) -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
    end
    rnd_out = (cmd.last ? sr : mc) ^ rk_next;
  end

  // Result and new feedback from the final keystream.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < cnt) begin
        out_c[127-8*i -: 8] = get_byte(data, i) ^ get_byte(rnd_out, i);
        fb_c[127-8*i -: 8]  = decrypt ? get_byte(data, i) : out_c[127-8*i -: 8];
      end else begin
        out_c[127-8*i -: 8] = 8'h00;
        fb_c[127-8*i -: 8]  = get_byte(fb, i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fb <= '0;
    end else if (cmd.load) begin
      fb <= fb_eff;
    end else if (cmd.finish) begin
      fb <= fb_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st   <= fb_eff ^ key;
      rk   <= key;
      rcon <= 8'h01;
      data <= din;
      cnt  <= cnt_sat;
    end else if (cmd.round) begin
      st   <= rnd_out;
      rk   <= rk_next;
      rcon <= xtime(rcon);
    end
    if (cmd.finish) begin
      res       <= out_c;
      res_count <= cnt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/aes128_cfb_cipher_unit.sv
// Top level of the AES-128 CFB-128 cipher unit.
//
//   channel  dir  payload                                      handshake
//   req      in   data_high, data_low, byte_count, first_block  req.valid/req.ready
//   res      out  out_high, out_low, out_count                  res.valid/res.ready
//   cfg      in   cfg_index, cfg_data                           cfg_we (no wait)
//
// A request is loaded in the cycle it is accepted and then runs ten AES rounds,
// one round per cycle through a single shared round unit whose round key is
// expanded alongside. Its result is registered after the final round and held
// valid until taken. A new request is accepted at the earliest in the cycle
// its predecessor's result is taken, so requests never overlap. Reset clears
// the controller, the feedback and all configuration registers. A stalled
// result holds the unit.
`default_nettype none
module aes128_cfb_cipher_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  aes_cfb_req_if.sink      req,
  aes_cfb_res_if.source    res
);
  import aes_cfb_pkg::*;

  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic        decrypt;
  dp_cmd_t     cmd;
  req_info_t   info;
  logic [127:0] res_block;

  // Configuration registers; the user must write them only while the unit is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      iv_high  <= '0;
      iv_low   <= '0;
      decrypt  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegKeyHigh: key_high <= cfg_data;
        RegKeyLow:  key_low  <= cfg_data;
        RegIvHigh:  iv_high  <= cfg_data;
        RegIvLow:   iv_low   <= cfg_data;
        RegDecrypt: decrypt  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign info.count = req.byte_count;
  assign info.first = req.first_block;

  aes_cfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(res.valid),
    .out_ready(res.ready),
    .cmd      (cmd)
  );

  aes_cfb_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .key      ({key_high, key_low}),
    .iv       ({iv_high, iv_low}),
    .decrypt  (decrypt),
    .din      ({req.data_high, req.data_low}),
    .info     (info),
    .res      (res_block),
    .res_count(res.out_count)
  );

  assign res.out_high = res_block[127:64];
  assign res.out_low  = res_block[63:0];
endmodule
`default_nettype wire

// File: bench/tb_aes128_cfb_cipher_unit.sv
// Self-checking testbench for the AES-128 CFB-128 cipher unit.
`default_nettype none
module tb_aes128_cfb_cipher_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import aes_cfb_pkg::*;

  // The run is far shorter than this; the counter only catches a hung unit.
  localparam int CycleLimit = 400000;
  // The drain pause leaves margin after the last result comes back.
  localparam int DrainCycles = 20;

  localparam logic [7:0] SubBytesTable [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  typedef struct packed {
    logic [63:0]          out_high;
    logic [63:0]          out_low;
    logic [CountBits-1:0] out_count;
  } cipher_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  aes_cfb_req_if req_ch ();
  aes_cfb_res_if res_ch ();

  aes128_cfb_cipher_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  // Local copy of the unit's programmable state and chaining register.
  logic [127:0]   cipher_key;
  logic [127:0]   init_vector;
  logic           decrypt_mode;
  logic [127:0]   chain_block;

  cipher_result_t expected_results[$];
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;
  // While set, neither side inserts idle cycles.
  bit             no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hung unit would otherwise leave the run waiting forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[aes128_cfb_cipher_unit] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Plain AES-128 block encryption: key schedule, then ten rounds.
  function automatic logic [127:0] block_keystream(input logic [127:0] key,
                                                   input logic [127:0] blk);
    logic [7:0]   sched[176];
    logic [7:0]   st[16];
    logic [7:0]   nx[16];
    logic [7:0]   word[4];
    logic [7:0]   rcon;
    logic [7:0]   hold;
    logic [7:0]   a0, a1, a2, a3, mix;
    logic [127:0] ciphered;
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) sched[i] = key[127-8*i -: 8];
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) word[j] = sched[4*(i-1)+j];
      if (i % 4 == 0) begin
        hold    = word[0];
        word[0] = SubBytesTable[word[1]] ^ rcon;
        word[1] = SubBytesTable[word[2]];
        word[2] = SubBytesTable[word[3]];
        word[3] = SubBytesTable[hold];
        rcon    = gf_double(rcon);
      end
      for (int j = 0; j < 4; j++) sched[4*i+j] = sched[4*(i-4)+j] ^ word[j];
    end
    for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8] ^ sched[i];
    for (int r = 1; r <= 10; r++) begin
      // SubBytes and ShiftRows together.
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) nx[c*4+i] = SubBytesTable[st[((c+i)%4)*4+i]];
      // MixColumns is skipped in the final round.
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = nx[c*4]; a1 = nx[c*4+1]; a2 = nx[c*4+2]; a3 = nx[c*4+3];
          mix = a0 ^ a1 ^ a2 ^ a3;
          nx[c*4]   = a0 ^ mix ^ gf_double(a0 ^ a1);
          nx[c*4+1] = a1 ^ mix ^ gf_double(a1 ^ a2);
          nx[c*4+2] = a2 ^ mix ^ gf_double(a2 ^ a3);
          nx[c*4+3] = a3 ^ mix ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = nx[i] ^ sched[16*r+i];
    end
    for (int i = 0; i < 16; i++) ciphered[127-8*i -: 8] = st[i];
    return ciphered;
  endfunction

  // CFB step: keystream from the chaining block, XOR into the valid bytes,
  // and refresh only those bytes of the chaining block.
  function automatic cipher_result_t cfb_process_block(input logic [63:0] dh,
                                                       input logic [63:0] dl,
                                                       input logic [4:0]  cnt,
                                                       input logic        first);
    cipher_result_t res;
    logic [127:0]   stream;
    logic [127:0]   din;
    logic [127:0]   dout;
    int             valid_bytes;
    if (first) chain_block = init_vector;
    valid_bytes = (cnt > 16) ? 16 : cnt;
    stream = block_keystream(cipher_key, chain_block);
    din    = {dh, dl};
    dout   = '0;
    for (int j = 0; j < valid_bytes; j++) begin
      dout[127-8*j -: 8] = din[127-8*j -: 8] ^ stream[127-8*j -: 8];
      chain_block[127-8*j -: 8] = decrypt_mode ? din[127-8*j -: 8] : dout[127-8*j -: 8];
    end
    res.out_high  = dout[127:64];
    res.out_low   = dout[63:0];
    res.out_count = CountBits'(valid_bytes);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s: got %h, expected %h", field, got, want);
    mismatch_count++;
  endtask

  // Drives one register write; load_settings drops the enable after the last one.
  task automatic write_register(input logic [CfgIdxBits-1:0] idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      RegKeyHigh: cipher_key[127:64]  = value;
      RegKeyLow:  cipher_key[63:0]    = value;
      RegIvHigh:  init_vector[127:64] = value;
      RegIvLow:   init_vector[63:0]   = value;
      RegDecrypt: decrypt_mode        = value[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [127:0] key, input logic [127:0] iv,
                               input logic [63:0] mode_word);
    write_register(RegKeyHigh, key[127:64]);
    write_register(RegKeyLow, key[63:0]);
    write_register(RegIvHigh, iv[127:64]);
    write_register(RegIvLow, iv[63:0]);
    write_register(RegDecrypt, mode_word);
    cfg_we <= 1'b0;
  endtask

  // Sends one request. The valid line stays high after acceptance so that a
  // back-to-back request never lowers and raises it in the same time step.
  task automatic send_request(input logic [63:0] dh, input logic [63:0] dl,
                              input logic [4:0] cnt, input logic first);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.data_high   <= dh;
    req_ch.data_low    <= dl;
    req_ch.byte_count  <= cnt;
    req_ch.first_block <= first;
    do @(posedge clk); while (!req_ch.ready);
    expected_results.push_back(cfb_process_block(dh, dl, cnt, first));
  endtask

  // Lowers valid and waits until every result is back, plus a drain pause.
  task automatic drain_unit();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Result side: random stall per result, then a field-by-field compare.
  initial begin
    cipher_result_t want;
    int             stall;
    res_ch.ready <= 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", res_ch.out_high, '0);
      end else begin
        want = expected_results.pop_front();
        if (res_ch.out_high !== want.out_high)
          report_mismatch("out_high", res_ch.out_high, want.out_high);
        if (res_ch.out_low !== want.out_low)
          report_mismatch("out_low", res_ch.out_low, want.out_low);
        if (res_ch.out_count !== want.out_count)
          report_mismatch("out_count", 64'(res_ch.out_count), 64'(want.out_count));
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Straight after reset the chaining block is zero and nothing has started a
  // message, so the unit must run on the all-zero block under the zero key.
  task automatic test_unstarted_chain();
    send_request('0, '0, 5'd16, 1'b0);
    send_request('1, '1, 5'd16, 1'b0);
    drain_unit();
  endtask

  // Standard CFB-128 vector: AES-128 key 2b7e..., IV 0001...0f.
  task automatic test_known_vector();
    load_settings(128'h2b7e151628aed2a6abf7158809cf4f3c,
                  128'h000102030405060708090a0b0c0d0e0f, 64'd0);
    send_request(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1);
    send_request(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd16, 1'b0);
    send_request(64'h30c81c46a35ce411, 64'he5fbc1191a0a52ef, 5'd16, 1'b0);
    drain_unit();
  endtask

  // Byte counts at and past the edges: none valid, one, one short of full,
  // full, and counts beyond sixteen that must saturate. Short blocks leave
  // the trailing chaining bytes as they were.
  task automatic test_byte_counts();
    send_request(rand64(), rand64(), 5'd0, 1'b1);
    send_request(rand64(), rand64(), 5'd1, 1'b0);
    send_request(rand64(), rand64(), 5'd15, 1'b0);
    send_request(rand64(), rand64(), 5'd16, 1'b0);
    send_request(rand64(), rand64(), 5'd17, 1'b0);
    send_request(rand64(), rand64(), 5'd31, 1'b0);
    send_request(rand64(), rand64(), 5'd8, 1'b1);
    drain_unit();
  endtask

  // Decryption feeds the received ciphertext back instead of the output.
  task automatic test_decrypt_mode();
    load_settings({rand64(), rand64()}, {rand64(), rand64()}, 64'd1);
    send_request('1, '1, 5'd16, 1'b1);
    send_request(rand64(), rand64(), 5'd16, 1'b0);
    send_request(rand64(), rand64(), 5'd9, 1'b0);
    send_request('0, '0, 5'd16, 1'b1);
    drain_unit();
  endtask

  // Mostly well-formed messages: a start block, full blocks, and a final block
  // that is often short. About one pass in ten sends a single noise request:
  // any count from the whole five-bit range and a start flag at random.
  task automatic run_messages(input int unsigned budget, input bit with_pause);
    int unsigned sent;
    int          blocks;
    logic [4:0]  cnt;
    sent = 0;
    while (sent < budget) begin
      // Runs without idle cycles on either side now and then.
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_request(rand64(), rand64(), 5'($urandom_range(0, 31)), 1'($urandom));
        sent++;
      end else begin
        blocks = $urandom_range(1, 8);
        for (int b = 0; b < blocks; b++) begin
          cnt = 5'd16;
          if (b == blocks - 1 && $urandom_range(0, 2) == 0) cnt = 5'($urandom_range(1, 16));
          send_request(rand64(), rand64(), cnt, b == 0);
          sent++;
        end
      end
      // Hold off until the unit has emptied, near the middle of the phase.
      if (with_pause && sent >= budget / 2 && sent < budget / 2 + 9) begin
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        @(posedge clk);
      end
    end
    no_idle = 1'b0;
    drain_unit();
  endtask

  // Random traffic under several settings, extremes first.
  task automatic test_random_traffic();
    load_settings('0, '0, 64'd0);
    run_messages(280, 1'b1);
    load_settings('1, '1, '1);
    run_messages(280, 1'b0);
    for (int p = 0; p < 4; p++) begin
      load_settings({rand64(), rand64()}, {rand64(), rand64()}, rand64());
      run_messages(280, p == 2);
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.data_high    <= '0;
    req_ch.data_low     <= '0;
    req_ch.byte_count   <= '0;
    req_ch.first_block  <= 1'b0;
    cipher_key     = '0;
    init_vector    = '0;
    decrypt_mode   = 1'b0;
    chain_block    = '0;
    no_idle        = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unstarted_chain();
    test_known_vector();
    test_byte_counts();
    test_decrypt_mode();
    test_random_traffic();

    if (mismatch_count == 0) begin
      $display("[aes128_cfb_cipher_unit] OK");
    end else begin
      $display("[aes128_cfb_cipher_unit] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
rtl/core/aes_cfb_pkg.sv
rtl/core/aes_cfb_if.sv
rtl/core/aes_cfb_ctrl.sv
rtl/core/aes_cfb_dp.sv
rtl/core/aes128_cfb_cipher_unit.sv
bench/tb_aes128_cfb_cipher_unit.sv
